// ===== rtl/multi_channel_timer_table_top_assert.svh =====
// Assertion macros shared by the timer table RTL.
// Both expect clk and rst_n in scope.
`ifndef MULTI_CHANNEL_TIMER_TABLE_TOP_ASSERT_SVH
`define MULTI_CHANNEL_TIMER_TABLE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");

// Consequent checked in the cycle after the antecedent.
`define MCTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

// ===== rtl/mctt_pkg.sv =====
package mctt_pkg;

  localparam int SLOT_W     = 4;
  localparam int INTERVAL_W = 24;
  localparam int WAIT_W     = 24;
  localparam int OUT_CNT_W  = 5;

  // input actions
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ARM    = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  // result kinds
  localparam logic [1:0] EV_FIRED       = 2'd0;
  localparam logic [1:0] EV_SUMMARY     = 2'd1;
  localparam logic [1:0] EV_ARM_DONE    = 2'd2;
  localparam logic [1:0] EV_CANCEL_DONE = 2'd3;

  // sweep token passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot;
    logic              periodic;
    logic              any;      // running minimum holds a real value
  } pkt_t;

endpackage

// ===== rtl/mctt_cell.sv =====
module mctt_cell #(
  parameter int IDX         = 0,
  parameter int COUNT_WIDTH = 24,
  parameter int CNT_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  mctt_pkg::pkt_t         pkt_in,
  input  logic [COUNT_WIDTH-1:0] load_in,
  input  logic [COUNT_WIDTH-1:0] wait_in,
  input  logic [CNT_W-1:0]       cnt_in,
  output mctt_pkg::pkt_t         pkt_out,
  output logic [COUNT_WIDTH-1:0] load_out,
  output logic [COUNT_WIDTH-1:0] wait_out,
  output logic [CNT_W-1:0]       cnt_out,
  output logic                   fire
);

  logic                   active_r, active_nxt;
  logic                   periodic_r, periodic_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] reload_r, reload_nxt;

  mctt_pkg::pkt_t         pkt_r, pkt_nxt;
  logic [COUNT_WIDTH-1:0] load_r;
  logic [COUNT_WIDTH-1:0] wait_r, wait_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   match;

  assign match = (int'(pkt_in.slot) == IDX);

  always_comb begin
    active_nxt   = active_r;
    periodic_nxt = periodic_r;
    rem_nxt      = rem_r;
    reload_nxt   = reload_r;
    fire         = 1'b0;
    if (pkt_in.valid) begin
      case (pkt_in.action)
        mctt_pkg::ACT_TICK: begin
          if (active_r) begin
            if (rem_r > COUNT_WIDTH'(1)) begin
              rem_nxt = rem_r - COUNT_WIDTH'(1);
            end else begin
              rem_nxt = '0;
              fire    = 1'b1;
              // reload a periodic slot; drop one-shot and zero-period slots
              if (periodic_r && (reload_r != '0)) begin
                rem_nxt = reload_r;
              end else begin
                active_nxt = 1'b0;
              end
            end
          end
        end
        mctt_pkg::ACT_ARM: begin
          if (match) begin
            active_nxt   = 1'b1;
            periodic_nxt = pkt_in.periodic;
            rem_nxt      = load_in;
            reload_nxt   = load_in;
          end
        end
        mctt_pkg::ACT_CANCEL: begin
          if (match) begin
            active_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // fold this slot's post-item state into the running summary
    pkt_nxt  = pkt_in;
    wait_nxt = wait_in;
    cnt_nxt  = cnt_in;
    if (active_nxt) begin
      if (!pkt_in.any || (rem_nxt < wait_in)) begin
        wait_nxt = rem_nxt;
      end
      pkt_nxt.any = 1'b1;
      cnt_nxt     = cnt_in + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pkt_r.valid <= 1'b0;
    end else if (advance) begin
      pkt_r  <= pkt_nxt;
      load_r <= load_in;
      wait_r <= wait_nxt;
      cnt_r  <= cnt_nxt;
      if (pkt_in.valid) begin
        active_r   <= active_nxt;
        periodic_r <= periodic_nxt;
        rem_r      <= rem_nxt;
        reload_r   <= reload_nxt;
      end
    end
  end

  assign pkt_out  = pkt_r;
  assign load_out = load_r;
  assign wait_out = wait_r;
  assign cnt_out  = cnt_r;

endmodule

// ===== rtl/multi_channel_timer_table_top.sv =====
// Timer table: NUM_SLOTS one-shot or periodic timers counted in millisecond ticks.
// Input channel (in_*): one transaction per command. in_tuser is the action
// (tick, arm, cancel); an undefined action is taken and dropped without result.
// Output channel (out_*): a tick gives one fired transaction per expiring slot,
// in ascending slot order, then a summary with tlast set. Arm and cancel give a
// single done transaction with tlast set carrying the least remaining count and
// the number of active slots.
// Each slot is a cell in a chain; a command token walks the chain one cell per
// cycle while the output is not stalled, updating the slot and folding it into a
// running minimum and count. The token passes the entry register and each cell's
// register in turn, and the closing result is then loaded into the output register
// and shows on out_tvalid. in_tready drops on acceptance and returns at the edge
// that loads the closing result, so no new command enters while one is in the chain.
// Any result that waits on out_tready freezes the whole chain until it is taken.
// Reset (rst_n low, synchronous) deactivates every slot and empties the chain
// and output register.
`include "multi_channel_timer_table_top_assert.svh"

module multi_channel_timer_table_top #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // slot[3:0], interval_ms[27:4], periodic[28], zero[31:29]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // fired_slot[3:0], next_wait[27:4], active_count[32:28],
                                  // zero[39:33]
  output logic [1:0]  out_tuser,  // event_kind[1:0]
  output logic        out_tlast   // last
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  mctt_pkg::pkt_t         pkt_c  [NUM_SLOTS+1];
  logic [COUNT_WIDTH-1:0] load_c [NUM_SLOTS+1];
  logic [COUNT_WIDTH-1:0] wait_c [NUM_SLOTS+1];
  logic [CNT_W-1:0]       cnt_c  [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0]   fire_vec;
  logic [NUM_SLOTS-1:0]   stage_valid;

  mctt_pkg::pkt_t         pkt0_r;
  logic [COUNT_WIDTH-1:0] load0_r;
  logic                   busy_r;

  logic                       out_valid_r;
  logic [1:0]                 out_kind_r;
  logic [mctt_pkg::SLOT_W-1:0] out_slot_r;
  logic [mctt_pkg::WAIT_W-1:0] out_wait_r;
  logic [mctt_pkg::OUT_CNT_W-1:0] out_cnt_r;
  logic                       out_last_r;

  logic                   advance;
  logic                   accept;
  logic                   launch;
  logic [31:0]            ival_ext;
  logic [COUNT_WIDTH-1:0] load_sat;
  logic [31:0]            fire_idx;
  logic [31:0]            wait_ext;
  logic [31:0]            cnt_ext;
  mctt_pkg::pkt_t         exit_pkt;
  logic [1:0]             sum_kind;
  logic [mctt_pkg::SLOT_W-1:0] sum_slot;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign launch    = accept && ((in_tuser == mctt_pkg::ACT_TICK) ||
                                (in_tuser == mctt_pkg::ACT_ARM) ||
                                (in_tuser == mctt_pkg::ACT_CANCEL));

  // saturate the interval to the counter width
  assign ival_ext = {8'd0, in_tdata[27:4]};
  assign load_sat = (ival_ext > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                           : ival_ext[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pkt0_r.valid <= 1'b0;
    end else begin
      if (launch) begin
        busy_r          <= 1'b1;
        pkt0_r.valid    <= 1'b1;
        pkt0_r.action   <= in_tuser;
        pkt0_r.slot     <= in_tdata[3:0];
        pkt0_r.periodic <= in_tdata[28];
        pkt0_r.any      <= 1'b0;
        load0_r         <= load_sat;
      end else begin
        if (advance) begin
          pkt0_r.valid <= 1'b0;
        end
        if (advance && exit_pkt.valid) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign pkt_c[0]  = pkt0_r;
  assign load_c[0] = load0_r;
  assign wait_c[0] = '0;
  assign cnt_c[0]  = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    mctt_cell #(
      .IDX         (i),
      .COUNT_WIDTH (COUNT_WIDTH),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .pkt_in   (pkt_c[i]),
      .load_in  (load_c[i]),
      .wait_in  (wait_c[i]),
      .cnt_in   (cnt_c[i]),
      .pkt_out  (pkt_c[i+1]),
      .load_out (load_c[i+1]),
      .wait_out (wait_c[i+1]),
      .cnt_out  (cnt_c[i+1]),
      .fire     (fire_vec[i])
    );
    assign stage_valid[i] = pkt_c[i+1].valid;
  end

  assign exit_pkt = pkt_c[NUM_SLOTS];

  // at most one cell holds the token, so fire_vec is one-hot or empty
  always_comb begin
    fire_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (fire_vec[i]) begin
        fire_idx = fire_idx | 32'(i);
      end
    end
  end

  assign wait_ext = exit_pkt.any ? 32'(wait_c[NUM_SLOTS]) : 32'd0;
  assign cnt_ext  = 32'(cnt_c[NUM_SLOTS]);

  always_comb begin
    case (exit_pkt.action)
      mctt_pkg::ACT_TICK: begin
        sum_kind = mctt_pkg::EV_SUMMARY;
        sum_slot = '0;
      end
      mctt_pkg::ACT_ARM: begin
        sum_kind = mctt_pkg::EV_ARM_DONE;
        sum_slot = exit_pkt.slot;
      end
      mctt_pkg::ACT_CANCEL: begin
        sum_kind = mctt_pkg::EV_CANCEL_DONE;
        sum_slot = exit_pkt.slot;
      end
      default: begin
        sum_kind = mctt_pkg::EV_SUMMARY;
        sum_slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= (|fire_vec) || exit_pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (|fire_vec) begin
        out_kind_r <= mctt_pkg::EV_FIRED;
        out_slot_r <= fire_idx[mctt_pkg::SLOT_W-1:0];
        out_wait_r <= '0;
        out_cnt_r  <= '0;
        out_last_r <= 1'b0;
      end else begin
        out_kind_r <= sum_kind;
        out_slot_r <= sum_slot;
        out_wait_r <= wait_ext[mctt_pkg::WAIT_W-1:0];
        out_cnt_r  <= cnt_ext[mctt_pkg::OUT_CNT_W-1:0];
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_wait_r, out_slot_r};

  `MCTT_ASSERT_NOW(a_fire_onehot, 1'b1, $onehot0(fire_vec))
  `MCTT_ASSERT_NOW(a_idle_chain_empty, !busy_r, (stage_valid == '0) && !pkt0_r.valid)
  `MCTT_ASSERT_NEXT(a_fire_held, (|fire_vec) && !advance, $stable(fire_vec))
  `MCTT_ASSERT_NEXT(a_close_last, advance && exit_pkt.valid && !(|fire_vec),
                    out_valid_r && out_last_r && !busy_r)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mctt_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam logic [1:0] ACT_UNDEF = 2'd3;
  localparam logic [INTERVAL_W-1:0] COUNT_MAX = '1;

  typedef struct {
    logic [1:0]            action;
    logic [SLOT_W-1:0]     slot;
    logic [INTERVAL_W-1:0] interval;
    logic                  periodic;
  } timer_cmd_t;

  typedef struct {
    logic [1:0]           kind;
    logic [SLOT_W-1:0]    slot_id;
    logic [WAIT_W-1:0]    min_left;
    logic [OUT_CNT_W-1:0] n_active;
    logic                 is_last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  multi_channel_timer_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Timer table shadow
  logic                  slot_on     [NUM_SLOTS];
  logic                  slot_repeat [NUM_SLOTS];
  logic [INTERVAL_W-1:0] slot_left   [NUM_SLOTS];
  logic [INTERVAL_W-1:0] slot_period [NUM_SLOTS];

  timer_cmd_t   command_queue[$];
  timer_event_t expected_events[$];
  int           n_cmds;
  int           items_taken;
  int           err_count;
  logic         in_hs;
  logic         out_hs;
  int           in_gap;
  int           out_stall;
  bit           in_calm;
  bit           out_calm;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_on[i]     = 1'b0;
      slot_repeat[i] = 1'b0;
      slot_left[i]   = '0;
      slot_period[i] = '0;
    end
    items_taken = 0;
    err_count   = 0;
    in_hs       = 1'b0;
    out_hs      = 1'b0;
    in_gap      = 0;
    out_stall   = 0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int draw_idle(input bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Closing result of an item: least remaining count and number of live slots.
  function automatic timer_event_t closing_event(input logic [1:0] kind,
                                                 input logic [SLOT_W-1:0] id);
    timer_event_t ev;
    logic seen;
    ev.kind     = kind;
    ev.slot_id  = id;
    ev.min_left = '0;
    ev.n_active = '0;
    ev.is_last  = 1'b1;
    seen        = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_on[i]) begin
        if (!seen || slot_left[i] < ev.min_left) ev.min_left = slot_left[i];
        seen = 1'b1;
        ev.n_active++;
      end
    end
    return ev;
  endfunction

  task automatic advance_timers(input logic [1:0] action, input logic [SLOT_W-1:0] slot,
                                input logic [INTERVAL_W-1:0] interval, input logic periodic);
    timer_event_t ev;
    case (action)
      ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i]) begin
            if (slot_left[i] > 1) begin
              slot_left[i]--;
            end else begin
              slot_left[i] = '0;
              ev.kind     = EV_FIRED;
              ev.slot_id  = SLOT_W'(i);
              ev.min_left = '0;
              ev.n_active = '0;
              ev.is_last  = 1'b0;
              expected_events = {expected_events, ev};
              // a periodic slot with zero period is dropped like a one-shot
              if (slot_repeat[i] && slot_period[i] != 0) slot_left[i] = slot_period[i];
              else slot_on[i] = 1'b0;
            end
          end
        end
        ev = closing_event(EV_SUMMARY, '0);
        expected_events = {expected_events, ev};
      end
      ACT_ARM: begin
        if (slot < NUM_SLOTS) begin
          slot_on[slot]     = 1'b1;
          slot_repeat[slot] = periodic;
          slot_left[slot]   = (interval > COUNT_MAX) ? COUNT_MAX : interval;
          slot_period[slot] = slot_left[slot];
        end
        ev = closing_event(EV_ARM_DONE, slot);
        expected_events = {expected_events, ev};
      end
      ACT_CANCEL: begin
        if (slot < NUM_SLOTS) slot_on[slot] = 1'b0;
        ev = closing_event(EV_CANCEL_DONE, slot);
        expected_events = {expected_events, ev};
      end
      default: ;
    endcase
  endtask

  task automatic check_event(input logic [1:0] kind, input logic [39:0] data,
                             input logic last);
    timer_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("result with none expected: kind %0d data %h", kind, data));
      return;
    end
    want = expected_events.pop_front();
    if (kind != want.kind)
      report_mismatch($sformatf("event_kind %0d, want %0d", kind, want.kind));
    if (data[3:0] != want.slot_id)
      report_mismatch($sformatf("fired_slot %0d, want %0d", data[3:0], want.slot_id));
    if (data[27:4] != want.min_left)
      report_mismatch($sformatf("next_wait %0d, want %0d", data[27:4], want.min_left));
    if (data[32:28] != want.n_active)
      report_mismatch($sformatf("active_count %0d, want %0d", data[32:28], want.n_active));
    if (last != want.is_last)
      report_mismatch($sformatf("tlast %0b, want %0b", last, want.is_last));
  endtask

  task automatic push_cmd(input logic [1:0] action, input int slot, input int interval,
                          input logic periodic);
    timer_cmd_t c;
    c.action   = action;
    c.slot     = SLOT_W'(slot);
    c.interval = INTERVAL_W'(interval);
    c.periodic = periodic;
    command_queue = {command_queue, c};
  endtask

  // Stimulus
  initial begin
    int n_items;
    int pick;
    int ival;

    push_cmd(ACT_TICK, 0, 0, 1'b0);
    push_cmd(ACT_CANCEL, 4, 0, 1'b0);
    push_cmd(ACT_ARM, 0, 0, 1'b0);
    push_cmd(ACT_ARM, 15, 0, 1'b1);
    push_cmd(ACT_ARM, 5, 24'hFFFFFF, 1'b1);
    push_cmd(ACT_ARM, 3, 1, 1'b1);
    push_cmd(ACT_ARM, 7, 2, 1'b0);
    push_cmd(ACT_UNDEF, 9, 123, 1'b1);
    push_cmd(ACT_TICK, 0, 0, 1'b0);
    push_cmd(ACT_TICK, 0, 0, 1'b0);
    push_cmd(ACT_ARM, 3, 5, 1'b0);
    push_cmd(ACT_ARM, 12, 1, 1'b1);
    push_cmd(ACT_ARM, 12, 3, 1'b1);
    push_cmd(ACT_TICK, 0, 0, 1'b0);
    push_cmd(ACT_CANCEL, 5, 0, 1'b0);
    push_cmd(ACT_CANCEL, 5, 0, 1'b0);
    push_cmd(ACT_ARM, 1, 24'hAAAAAA, 1'b0);
    push_cmd(ACT_ARM, 2, 24'h555555, 1'b1);
    push_cmd(ACT_TICK, 0, 0, 1'b0);
    push_cmd(ACT_CANCEL, 1, 0, 1'b0);
    push_cmd(ACT_CANCEL, 2, 0, 1'b0);
    push_cmd(ACT_CANCEL, 3, 0, 1'b0);
    push_cmd(ACT_CANCEL, 12, 0, 1'b0);
    push_cmd(ACT_TICK, 0, 0, 1'b0);

    n_items = command_queue.size();
    while (n_items < 320) begin
      if ($urandom_range(0, 24) == 0) begin
        // fill the whole table with short timers, then let them run
        for (int s = 0; s < NUM_SLOTS; s++)
          push_cmd(ACT_ARM, s, $urandom_range(0, 3), 1'($urandom()));
        pick = $urandom_range(2, 5);
        for (int t = 0; t < pick; t++) push_cmd(ACT_TICK, 0, 0, 1'b0);
        n_items += NUM_SLOTS + pick;
      end else begin
        pick = $urandom_range(0, 99);
        ival = $urandom_range(0, 9);
        if (ival < 6) ival = $urandom_range(0, 4);
        else if (ival < 8) ival = $urandom_range(0, 60);
        else ival = $urandom() & 32'h00FF_FFFF;
        if (pick < 45) begin
          push_cmd(ACT_TICK, $urandom_range(0, 15), $urandom(), 1'($urandom()));
          n_items++;
        end else if (pick < 80) begin
          push_cmd(ACT_ARM, $urandom_range(0, 15), ival, 1'($urandom()));
          n_items++;
        end else if (pick < 95) begin
          push_cmd(ACT_CANCEL, $urandom_range(0, 15), $urandom(), 1'($urandom()));
          n_items++;
        end else begin
          push_cmd(ACT_UNDEF, $urandom_range(0, 15), $urandom(), 1'($urandom()));
          n_items++;
        end
      end
    end
    n_cmds = command_queue.size();
  end

  // Input driver
  always @(negedge clk) begin : drive_in
    timer_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_hs) begin
      // hold until the transaction is taken
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (command_queue.size() > 0) begin
      c = command_queue.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {3'b000, c.periodic, c.interval, c.slot};
      in_tuser  <= c.action;
      if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
      in_gap = draw_idle(in_calm);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_hs) begin
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        out_stall = draw_idle(out_calm);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_hs  <= 1'b0;
      out_hs <= 1'b0;
    end else begin
      in_hs  <= in_tvalid && in_tready;
      out_hs <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        advance_timers(in_tuser, in_tdata[3:0], in_tdata[27:4], in_tdata[28]);
        items_taken++;
      end
      if (out_tvalid && out_tready) check_event(out_tuser, out_tdata, out_tlast);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (items_taken < n_cmds) @(negedge clk);
    while (expected_events.size() != 0) @(negedge clk);
    // drain: let any trailing result show up
    repeat (40) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_events.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
